FILE: src/llmac_pkg.sv
// Shared types and codes for the fully connected layer multiply-accumulate block.
package llmac_pkg;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_ACT    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_INPUT_LENGTH = 2'd0,
        CFG_OUTPUT_COUNT = 2'd1,
        CFG_ROW_COUNT    = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 9;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         neuron_index;
        logic [5:0]         element_index;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         neuron_out;
        logic signed [31:0] result;
        logic               saturated;
        logic               last;
        logic               batch_done;
    } out_item_t;

    // Control that travels down the MAC pipeline with each operand pair
    typedef struct packed {
        logic valid;
        logic first;
        logic fin;
    } mac_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_RUN,
        ST_DRAIN
    } seq_state_t;

endpackage

FILE: src/llmac_store.sv
// Weight, bias and activation memories with registered read ports.
module llmac_store #(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_NEURONS = 16,
    parameter int IW          = 6,
    parameter int NW          = 4
) (
    input  logic                 aclk,
    input  logic                 weight_we,
    input  logic                 bias_we,
    input  logic                 act_we,
    input  logic [NW-1:0]        wr_neuron,
    input  logic [IW-1:0]        wr_element,
    input  logic signed [15:0]   wr_value,
    input  logic [NW-1:0]        rd_neuron,
    input  logic [IW-1:0]        rd_element,
    output logic signed [15:0]   rd_act,
    output logic signed [15:0]   rd_weight,
    output logic signed [15:0]   rd_bias
);
    import llmac_pkg::*;

    logic signed [15:0] weight_mem [MAX_NEURONS][MAX_INPUTS];
    logic signed [15:0] bias_mem   [MAX_NEURONS];
    logic signed [15:0] act_mem    [MAX_INPUTS];

    always_ff @(posedge aclk) begin
        if (weight_we) begin
            weight_mem[wr_neuron][wr_element] <= wr_value;
        end
        rd_weight <= weight_mem[rd_neuron][rd_element];
    end

    always_ff @(posedge aclk) begin
        if (bias_we) begin
            bias_mem[wr_neuron] <= wr_value;
        end
        rd_bias <= bias_mem[rd_neuron];
    end

    always_ff @(posedge aclk) begin
        if (act_we) begin
            act_mem[wr_element] <= wr_value;
        end
        rd_act <= act_mem[rd_element];
    end

endmodule

FILE: src/llmac_mac.sv
// Shared multiply-accumulate unit with bias alignment, rounding and saturation.
module llmac_mac #(
    parameter int IW = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  llmac_pkg::mac_ctl_t  issue,
    input  logic signed [15:0]   act,
    input  logic signed [15:0]   weight,
    input  logic signed [15:0]   bias,
    output logic                 res_valid,
    output logic signed [31:0]   res_value,
    output logic                 res_sat
);
    import llmac_pkg::*;

    localparam int AW = 33 + IW;
    localparam int QW = AW - 11;
    localparam int QX = (QW > 33) ? QW : 33;
    localparam logic signed [AW:0]   ROUND_HALF = (AW+1)'(2048);
    localparam logic signed [QX-1:0] Q_MAX = QX'(32'sh7fffffff);
    localparam logic signed [QX-1:0] Q_MIN = QX'(32'sh80000000);

    mac_ctl_t           ctl1_reg, ctl2_reg, ctl3_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] bias2_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] bias_al;
    logic signed [AW:0]   rounded;
    logic signed [QW-1:0] q;
    logic signed [QX-1:0] q_x;
    logic                 res_valid_reg;
    logic signed [31:0]   res_value_reg;
    logic                 res_sat_reg;

    // Bias is Q4.12; lift it to the Q8.24 scale of the products
    assign bias_al = $signed({{(AW-28){bias2_reg[15]}}, bias2_reg, 12'b0});

    always_comb begin
        if (ctl2_reg.first) begin
            acc_next = AW'(prod_reg) + bias_al;
        end else begin
            acc_next = acc_reg + AW'(prod_reg);
        end
    end

    // Round half up, then floor-shift to Q20.12
    assign rounded = (AW+1)'(acc_reg) + ROUND_HALF;
    assign q       = $signed(rounded[AW:12]);
    assign q_x     = QX'(q);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg      <= '0;
            ctl2_reg      <= '0;
            ctl3_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            ctl1_reg      <= issue;
            ctl2_reg      <= ctl1_reg;
            ctl3_reg      <= ctl2_reg;
            res_valid_reg <= ctl3_reg.valid && ctl3_reg.fin;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= act * weight;
        bias2_reg <= bias;
        if (ctl2_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (q_x > Q_MAX) begin
            res_value_reg <= 32'sh7fffffff;
            res_sat_reg   <= 1'b1;
        end else if (q_x < Q_MIN) begin
            res_value_reg <= 32'sh80000000;
            res_sat_reg   <= 1'b1;
        end else begin
            res_value_reg <= q_x[31:0];
            res_sat_reg   <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_value = res_value_reg;
    assign res_sat   = res_sat_reg;

endmodule

FILE: src/llmac_seq.sv
// Sequencer that walks neurons and row elements through the shared MAC.
module llmac_seq #(
    parameter int IW = 6,
    parameter int NW = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [IW-1:0]        len_m1,
    input  logic [NW-1:0]        cnt_m1,
    input  logic                 out_full,
    input  logic                 res_valid,
    output llmac_pkg::mac_ctl_t  issue,
    output logic [NW-1:0]        neuron,
    output logic [IW-1:0]        element,
    output logic                 idle
);
    import llmac_pkg::*;

    seq_state_t    state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [IW-1:0] i_reg, i_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        issue.valid = 1'b0;
        issue.first = (i_reg == '0);
        issue.fin   = (i_reg == len_m1);
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    n_next     = '0;
                    state_next = ST_WAIT;
                end
            end
            // Hold until the previous result has left the output word
            ST_WAIT: begin
                if (!out_full) begin
                    i_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                issue.valid = 1'b1;
                if (i_reg == len_m1) begin
                    state_next = ST_DRAIN;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (res_valid) begin
                    if (n_reg == cnt_m1) begin
                        state_next = ST_IDLE;
                    end else begin
                        n_next     = n_reg + 1'b1;
                        state_next = ST_WAIT;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign neuron  = n_reg;
    assign element = i_reg;
    assign idle    = (state_reg == ST_IDLE);

endmodule

FILE: src/linear_layer_mac_unit.sv
// Top level of the fully connected layer: configuration, stores, sequencer and MAC.
//
// Weight, bias and activation words are taken one per cycle. The activation
// word that completes a row (element input_length-1) starts a run: one shared
// 16x16 multiplier-accumulator walks the row for each neuron in turn, one
// product per cycle, waiting between neurons until the result has drained and
// the output word is empty. s_ready is low for the run; the final result may
// still sit in the output register while the next word is taken. Results come
// out in neuron order, Q20.12 rounded half up and saturated to 32 bits. The
// stores have no reset and hold their contents across configuration writes;
// the batch row counter clears on reset and at the end of each batch.
module linear_layer_mac_unit #(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_NEURONS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  llmac_pkg::in_item_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output llmac_pkg::out_item_t                 m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  llmac_pkg::cfg_index_t                cfg_index,
    input  logic [llmac_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import llmac_pkg::*;

    localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int NW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int EXW = (IW > 6) ? IW : 6;
    localparam int NXW = (NW > 4) ? NW : 4;

    logic [6:0] len_cfg_reg;
    logic [4:0] cnt_cfg_reg;
    logic [8:0] rows_cfg_reg;
    logic [7:0] row_ctr_reg;
    logic       done_reg;

    logic [IW-1:0] len_m1;
    logic [NW-1:0] cnt_m1;
    logic [8:0]    rows_cl;

    logic           s_acc;
    logic [EXW-1:0] ei_x;
    logic [NXW-1:0] ni_x;
    logic           ei_ok, ni_ok;
    logic           row_end;
    logic           batch_end;

    mac_ctl_t           issue;
    logic [NW-1:0]      rd_neuron;
    logic [IW-1:0]      rd_element;
    logic               seq_idle;
    logic signed [15:0] rd_act, rd_weight, rd_bias;
    logic               res_valid;
    logic signed [31:0] res_value;
    logic               res_sat;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;
    logic [NXW-1:0] n_x;

    // Clamp registers to their working ranges; zero acts as one
    always_comb begin : clamp_proc
        int len_i;
        int cnt_i;
        len_i = int'(len_cfg_reg);
        cnt_i = int'(cnt_cfg_reg);
        if (len_i == 0) len_i = 1;
        if (len_i > MAX_INPUTS) len_i = MAX_INPUTS;
        if (cnt_i == 0) cnt_i = 1;
        if (cnt_i > MAX_NEURONS) cnt_i = MAX_NEURONS;
        len_m1 = IW'(len_i - 1);
        cnt_m1 = NW'(cnt_i - 1);
        if (rows_cfg_reg == 9'd0) begin
            rows_cl = 9'd1;
        end else if (rows_cfg_reg > 9'd256) begin
            rows_cl = 9'd256;
        end else begin
            rows_cl = rows_cfg_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = seq_idle;
    assign s_acc     = s_valid && s_ready;

    assign ei_x  = EXW'(s_data.element_index);
    assign ni_x  = NXW'(s_data.neuron_index);
    assign ei_ok = (int'(s_data.element_index) < MAX_INPUTS);
    assign ni_ok = (int'(s_data.neuron_index) < MAX_NEURONS);

    assign row_end   = s_acc && (s_data.operation == OP_ACT) && ei_ok
                       && (ei_x == EXW'(len_m1));
    assign batch_end = ((9'(row_ctr_reg) + 9'd1) >= rows_cl);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg  <= 7'd64;
            cnt_cfg_reg  <= 5'd16;
            rows_cfg_reg <= 9'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_INPUT_LENGTH: len_cfg_reg  <= cfg_data[6:0];
                CFG_OUTPUT_COUNT: cnt_cfg_reg  <= cfg_data[4:0];
                CFG_ROW_COUNT:    rows_cfg_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Latch the batch flag for the run and advance the row counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ctr_reg <= '0;
            done_reg    <= 1'b0;
        end else if (row_end) begin
            done_reg    <= batch_end;
            row_ctr_reg <= batch_end ? 8'd0 : row_ctr_reg + 8'd1;
        end
    end

    llmac_store #(
        .MAX_INPUTS (MAX_INPUTS),
        .MAX_NEURONS(MAX_NEURONS),
        .IW         (IW),
        .NW         (NW)
    ) u_store (
        .aclk      (aclk),
        .weight_we (s_acc && (s_data.operation == OP_WEIGHT) && ni_ok && ei_ok),
        .bias_we   (s_acc && (s_data.operation == OP_BIAS) && ni_ok),
        .act_we    (s_acc && (s_data.operation == OP_ACT) && ei_ok),
        .wr_neuron (ni_x[NW-1:0]),
        .wr_element(ei_x[IW-1:0]),
        .wr_value  (s_data.value),
        .rd_neuron (rd_neuron),
        .rd_element(rd_element),
        .rd_act    (rd_act),
        .rd_weight (rd_weight),
        .rd_bias   (rd_bias)
    );

    llmac_seq #(
        .IW(IW),
        .NW(NW)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (row_end),
        .len_m1   (len_m1),
        .cnt_m1   (cnt_m1),
        .out_full (m_valid_reg),
        .res_valid(res_valid),
        .issue    (issue),
        .neuron   (rd_neuron),
        .element  (rd_element),
        .idle     (seq_idle)
    );

    llmac_mac #(
        .IW(IW)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .issue    (issue),
        .act      (rd_act),
        .weight   (rd_weight),
        .bias     (rd_bias),
        .res_valid(res_valid),
        .res_value(res_value),
        .res_sat  (res_sat)
    );

    // Output word: loaded only when empty, since the sequencer waits for it
    assign n_x = NXW'(rd_neuron);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg.neuron_out <= n_x[3:0];
            m_data_reg.result     <= res_value;
            m_data_reg.saturated  <= res_sat;
            m_data_reg.last       <= (rd_neuron == cnt_m1);
            m_data_reg.batch_done <= (rd_neuron == cnt_m1) && done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
